// ===== design/double_ended_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_core_defines
// Assertion macros used by the deque controller.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// concurrent check with a generic message
`define DEQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deque assertion failed");
// concurrent check with its own message
`define DEQ_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk, rst_n, prop)
`define DEQ_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Types, command and status codes and ring helpers of the deque core.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // sizing
  localparam int Depth  = 16;
  localparam int ValueW = 32;
  localparam int IdxW   = $clog2(Depth);
  localparam int CntW   = $clog2(Depth + 1);

  // fixed field widths of the command and result beats
  localparam int CmdW    = 3;
  localparam int DataW   = 32;
  localparam int StatusW = 2;
  localparam int FillW   = 5;

  // command codes
  localparam logic [CmdW-1:0] CmdPushFront = 3'd0;
  localparam logic [CmdW-1:0] CmdPushBack  = 3'd1;
  localparam logic [CmdW-1:0] CmdPopFront  = 3'd2;
  localparam logic [CmdW-1:0] CmdPopBack   = 3'd3;
  localparam logic [CmdW-1:0] CmdPeekFront = 3'd4;
  localparam logic [CmdW-1:0] CmdPeekBack  = 3'd5;

  // status codes
  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  // command beat
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] push_value;
  } cmd_t;

  // result beat
  typedef struct packed {
    logic [DataW-1:0]   read_value;
    logic [StatusW-1:0] status;
    logic [FillW-1:0]   fill_count;
  } rsp_t;

  // entry store access issued by the controller
  typedef struct packed {
    logic              en;
    logic              we;
    logic [IdxW-1:0]   addr;
    logic [ValueW-1:0] wdata;
  } ram_req_t;

  // result info registered to line up with the store read data
  typedef struct packed {
    logic               valid;
    logic               rd;
    logic [StatusW-1:0] status;
    logic [FillW-1:0]   fill;
  } stage_t;

  // ring pointer step forward
  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] r;
    if (i == IdxW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = i + IdxW'(1);
    end
    return r;
  endfunction

  // ring pointer step back
  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] r;
    if (i == '0) begin
      r = IdxW'(Depth - 1);
    end else begin
      r = i - IdxW'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of 16 value handles held in one RAM ring.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge where start is high and busy is low;
// busy is high only from reset until the first clock edge after reset is
// released, so one command per cycle is taken after that. Every command
// gives exactly one result beat, shown on result_o with result_valid_o high
// for one cycle, starting the cycle after the command was taken; the
// receiver cannot stall it. This delay comes from the registered read
// port of the entry RAM. A pop or peek sees every earlier push, including
// one taken in the cycle just before. The RAM is not cleared; only entries
// written by a push are ever read.
`default_nettype none

module double_ended_queue_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output      logic          busy,
  input  wire deq_pkg::cmd_t cmd_i,
  output      logic          result_valid_o,
  output      deq_pkg::rsp_t result_o
);

  logic                       busy_q;
  logic                       accept;
  deq_pkg::ram_req_t          ram_req;
  deq_pkg::stage_t            stage;
  logic [deq_pkg::ValueW-1:0] ram_rdata;

  // held off only right after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  // pointers, count and command decode
  deq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (cmd_i),
    .ram_req_o (ram_req),
    .stage_o   (stage)
  );

  // entry store
  deq_ram #(
    .Width (deq_pkg::ValueW),
    .Depth (deq_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_req.en),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // result beat
  assign result_valid_o      = stage.valid;
  assign result_o.read_value = stage.rd ? deq_pkg::DataW'(ram_rdata) : '0;
  assign result_o.status     = stage.status;
  assign result_o.fill_count = stage.fill;

endmodule

`default_nettype wire

// ===== design/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write or registered read, one access per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Front/back pointers and count of the deque; issues at most one entry store
// access per command and registers the result info for the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_core_defines.svh"

module deq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire deq_pkg::cmd_t     cmd_i,
  output      deq_pkg::ram_req_t ram_req_o,
  output      deq_pkg::stage_t   stage_o
);

  logic [deq_pkg::IdxW-1:0] front_q, front_d;
  logic [deq_pkg::IdxW-1:0] back_q, back_d;
  logic [deq_pkg::CntW-1:0] count_q, count_d;
  deq_pkg::stage_t          stage_q, stage_d;
  deq_pkg::ram_req_t        req;
  logic                     full, empty;

  assign full  = (count_q == deq_pkg::CntW'(deq_pkg::Depth));
  assign empty = (count_q == '0);

  // command decode, pointer update and store access
  always_comb begin
    front_d        = front_q;
    back_d         = back_q;
    count_d        = count_q;
    req.en         = 1'b0;
    req.we         = 1'b0;
    req.addr       = front_q;
    req.wdata      = deq_pkg::ValueW'(cmd_i.push_value);
    stage_d.valid  = accept_i;
    stage_d.rd     = 1'b0;
    stage_d.status = deq_pkg::StOk;
    if (accept_i) begin
      unique case (cmd_i.cmd)
        deq_pkg::CmdPushFront: begin
          if (full) begin
            stage_d.status = deq_pkg::StFull;
          end else begin
            front_d  = deq_pkg::idx_dec(front_q);
            req.en   = 1'b1;
            req.we   = 1'b1;
            req.addr = deq_pkg::idx_dec(front_q);
            count_d  = count_q + deq_pkg::CntW'(1);
          end
        end
        deq_pkg::CmdPushBack: begin
          if (full) begin
            stage_d.status = deq_pkg::StFull;
          end else begin
            back_d   = deq_pkg::idx_inc(back_q);
            req.en   = 1'b1;
            req.we   = 1'b1;
            req.addr = back_q;
            count_d  = count_q + deq_pkg::CntW'(1);
          end
        end
        deq_pkg::CmdPopFront, deq_pkg::CmdPeekFront: begin
          if (empty) begin
            stage_d.status = deq_pkg::StEmpty;
          end else begin
            req.en     = 1'b1;
            req.addr   = front_q;
            stage_d.rd = 1'b1;
            if (cmd_i.cmd == deq_pkg::CmdPopFront) begin
              front_d = deq_pkg::idx_inc(front_q);
              count_d = count_q - deq_pkg::CntW'(1);
            end
          end
        end
        deq_pkg::CmdPopBack, deq_pkg::CmdPeekBack: begin
          if (empty) begin
            stage_d.status = deq_pkg::StEmpty;
          end else begin
            req.en     = 1'b1;
            req.addr   = deq_pkg::idx_dec(back_q);
            stage_d.rd = 1'b1;
            if (cmd_i.cmd == deq_pkg::CmdPopBack) begin
              back_d  = deq_pkg::idx_dec(back_q);
              count_d = count_q - deq_pkg::CntW'(1);
            end
          end
        end
        default: begin
          // unused codes leave the state alone
        end
      endcase
    end
    stage_d.fill = deq_pkg::FillW'(count_d);
  end

  // pointer, count and result info registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
      stage_q <= '0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
      stage_q <= stage_d;
    end
  end

  assign ram_req_o = req;
  assign stage_o   = stage_q;

  // checks
  `DEQ_ASSERT_MSG(count_in_range_a, clk_i, rst_ni, count_q <= deq_pkg::CntW'(deq_pkg::Depth), "count above depth")
  `DEQ_ASSERT_MSG(ptr_meet_a, clk_i, rst_ni, (count_q == '0 || full) |-> front_q == back_q, "pointers apart at empty or full")
  `DEQ_ASSERT(beat_follows_accept_a, clk_i, rst_ni, accept_i |=> stage_q.valid)
  `DEQ_ASSERT(no_beat_without_accept_a, clk_i, rst_ni, !accept_i |=> !stage_q.valid)
  `DEQ_ASSERT_MSG(full_push_flagged_a, clk_i, rst_ni, (accept_i && full && (cmd_i.cmd == deq_pkg::CmdPushFront || cmd_i.cmd == deq_pkg::CmdPushBack)) |=> (stage_q.status == deq_pkg::StFull && !stage_q.rd), "push on full not flagged")

endmodule

`default_nettype wire
